// ===== hdl/sbl_pkg.sv =====
// Shared types, byte codes and helpers of the script byte lexer.
package sbl_pkg;

	// Default width of the position and line counters
	localparam int COUNT_WIDTH_DEFAULT = 32;

	// Byte codes with a meaning of their own
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_AMP       = 8'h26;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_EQUALS    = 8'h3D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_PIPE      = 8'h7C;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	// Lexer mode
	typedef enum logic [2:0] {
		LEX_IDLE    = 3'd0,
		LEX_TOKEN   = 3'd1,
		LEX_STRING  = 3'd2,
		LEX_ESCAPE  = 3'd3,
		LEX_COMMENT = 3'd4
	} lex_mode_t;

	// Byte class
	typedef enum logic [1:0] {
		CLS_ORDINARY = 2'd0,
		CLS_SPACE    = 2'd1,
		CLS_DELIM    = 2'd2
	} byte_class_t;

	// One token result
	typedef struct packed {
		logic [31:0] token_offset;
		logic [31:0] token_size;
		logic [31:0] token_line_no;
		logic        end_marker;
		logic        open_string;
	} result_t;

	// Results of one byte, handed from the lexer core to the result queue
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} lex_out_t;

	// Classify a byte as ordinary, white space or delimiter
	function automatic byte_class_t byte_class(input logic [7:0] c);
		byte_class_t cls;
		unique case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT, CH_NUL:
				cls = CLS_SPACE;
			CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
			CH_COLON, CH_COMMA, CH_EQUALS, CH_PLUS, CH_MINUS, CH_STAR,
			CH_SLASH, CH_AMP, CH_PIPE:
				cls = CLS_DELIM;
			default:
				cls = CLS_ORDINARY;
		endcase
		return cls;
	endfunction

endpackage

// ===== hdl/sbl_if.sv =====
// Valid/ready channels of the script byte lexer: raw bytes in, token results out.
interface sbl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sbl_token_if;
	logic        valid;
	logic        ready;
	logic [31:0] token_offset;
	logic [31:0] token_size;
	logic [31:0] token_line_no;
	logic        end_marker;
	logic        open_string;

	modport source (output valid, output token_offset, output token_size,
		output token_line_no, output end_marker, output open_string, input ready);
	modport sink (input valid, input token_offset, input token_size,
		input token_line_no, input end_marker, input open_string, output ready);
endinterface

// ===== hdl/script_byte_lexer.sv =====
// Script byte lexer top level: input register, lexer core and result queue.
//
// chars:  one script byte per request (data_byte, final_byte), valid/ready.
// tokens: one token boundary per request (token_offset, token_size,
//         token_line_no, end_marker, open_string), valid/ready.
// A byte is taken into the input register and processed once the result
// queue has room for two results; its results are then written into the
// queue, which shows them on tokens in order.
// One byte enters every cycle while the queue has room; a byte gives zero,
// one or two results, and the queue sends one result per cycle, so the input
// rate is one byte per cycle while the output keeps up and falls to the output
// rate when delimiters that end a token produce result pairs back to back.
// The final byte always yields a result marked end_marker, and the counters
// then start again from offset 0 and line 1.
// Reset clears the lexer to idle, position 0, line 1, and empties the queue.
// When tokens stalls, the queue fills; once fewer than two slots remain the
// held byte waits and chars drops ready. No request is dropped.
module script_byte_lexer #(
	parameter int COUNT_WIDTH = sbl_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	sbl_byte_if.sink    chars,
	sbl_token_if.source tokens
);
	import sbl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       room;
	logic       step;
	lex_out_t   lex_res;

	// Process the held byte once the queue can take its results
	assign step        = valid_s1 && room;
	assign chars.ready = !valid_s1 || room;

	// Hold the input request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1  <= chars.data_byte;
			final_s1 <= chars.final_byte;
		end
	end

	sbl_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.res        (lex_res)
	);

	sbl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.din    (lex_res),
		.room   (room),
		.tokens (tokens)
	);

endmodule

// ===== hdl/sbl_core.sv =====
// Lexer state and the per-byte mode update that yields up to two results.
module sbl_core #(
	parameter int COUNT_WIDTH = sbl_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output sbl_pkg::lex_out_t res
);
	import sbl_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

	lex_mode_t              mode_q, mode_n;
	logic [COUNT_WIDTH-1:0] pos_q, np;
	logic [COUNT_WIDTH-1:0] beg_q, beg_n;
	logic [COUNT_WIDTH-1:0] line_q, line_n;
	byte_class_t            cls;
	logic                   pending;
	result_t                r0, r1;
	logic [1:0]             n;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic result_t make_result(input logic [COUNT_WIDTH-1:0] off,
			input logic [COUNT_WIDTH-1:0] size, input logic [COUNT_WIDTH-1:0] line,
			input logic endm, input logic open);
		result_t r;
		r.token_offset  = 32'(off);
		r.token_size    = 32'(size);
		r.token_line_no = 32'(line);
		r.end_marker    = endm;
		r.open_string   = open;
		return r;
	endfunction

	// Work out the next mode and the results of this byte
	always_comb begin
		cls    = byte_class(data_byte);
		np     = sat_inc(pos_q);
		line_n = (data_byte == CH_LF) ? sat_inc(line_q) : line_q;
		mode_n = mode_q;
		beg_n  = beg_q;
		r0     = '0;
		r1     = '0;
		n      = 2'd0;

		unique case (mode_q)
			LEX_STRING: begin
				if (data_byte == CH_BACKSLASH) begin
					mode_n = LEX_ESCAPE;
				end else if (data_byte == CH_QUOTE) begin
					mode_n = LEX_TOKEN;
				end
			end
			LEX_ESCAPE: begin
				mode_n = LEX_STRING;
			end
			LEX_COMMENT: begin
				if (data_byte == CH_LF) begin
					mode_n = LEX_IDLE;
				end
			end
			LEX_TOKEN: begin
				if (data_byte == CH_HASH) begin
					r0     = make_result(beg_q, pos_q - beg_q, line_n, 1'b0, 1'b0);
					n      = 2'd1;
					mode_n = LEX_COMMENT;
				end else if (data_byte == CH_QUOTE) begin
					mode_n = LEX_STRING;
				end else if (cls == CLS_SPACE) begin
					r0     = make_result(beg_q, pos_q - beg_q, line_n, 1'b0, 1'b0);
					n      = 2'd1;
					mode_n = LEX_IDLE;
				end else if (cls == CLS_DELIM) begin
					r0     = make_result(beg_q, pos_q - beg_q, line_n, 1'b0, 1'b0);
					r1     = make_result(pos_q, CNT_ONE, line_n, 1'b0, 1'b0);
					n      = 2'd2;
					mode_n = LEX_IDLE;
				end
			end
			default: begin
				// idle, and any code that cannot arise
				if (data_byte == CH_HASH) begin
					mode_n = LEX_COMMENT;
				end else if (data_byte == CH_QUOTE) begin
					beg_n  = pos_q;
					mode_n = LEX_STRING;
				end else if (cls == CLS_DELIM) begin
					r0     = make_result(pos_q, CNT_ONE, line_n, 1'b0, 1'b0);
					n      = 2'd1;
					mode_n = LEX_IDLE;
				end else if (cls == CLS_ORDINARY) begin
					beg_n  = pos_q;
					mode_n = LEX_TOKEN;
				end else begin
					mode_n = LEX_IDLE;
				end
			end
		endcase

		// Close the input on the final byte
		pending = (mode_n == LEX_TOKEN) || (mode_n == LEX_STRING) || (mode_n == LEX_ESCAPE);
		if (final_byte) begin
			if (pending) begin
				if (n == 2'd0) begin
					r0 = make_result(beg_n, np - beg_n, line_n, 1'b1, mode_n != LEX_TOKEN);
				end else begin
					r1 = make_result(beg_n, np - beg_n, line_n, 1'b1, mode_n != LEX_TOKEN);
				end
				n = n + 2'd1;
			end else if (n == 2'd1) begin
				r0.end_marker = 1'b1;
			end else if (n == 2'd2) begin
				r1.end_marker = 1'b1;
			end else begin
				r0 = make_result(np, CNT_ZERO, line_n, 1'b1, 1'b0);
				n  = 2'd1;
			end
		end

		res.count  = n;
		res.first  = r0;
		res.second = r1;
	end

	// Advance the state on each processed byte; drop back to reset after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LEX_IDLE;
			pos_q  <= CNT_ZERO;
			beg_q  <= CNT_ZERO;
			line_q <= CNT_ONE;
		end else if (step) begin
			if (final_byte) begin
				mode_q <= LEX_IDLE;
				pos_q  <= CNT_ZERO;
				beg_q  <= CNT_ZERO;
				line_q <= CNT_ONE;
			end else begin
				mode_q <= mode_n;
				pos_q  <= np;
				beg_q  <= beg_n;
				line_q <= line_n;
			end
		end
	end

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> mode_q == LEX_IDLE && pos_q == CNT_ZERO && line_q == CNT_ONE)
		else $error("lexer state not restored after final byte");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |-> res.count != 2'd0)
		else $error("final byte produced no result");

	a_marker_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && !final_byte |-> !res.first.end_marker && !res.second.end_marker)
		else $error("end marker on a byte that is not final");

	a_begin_not_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		beg_q <= pos_q)
		else $error("token start beyond byte position");

endmodule

// ===== hdl/sbl_queue.sv =====
// Four-entry result queue: takes up to two results a cycle, hands out one.
module sbl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbl_pkg::lex_out_t din,
	output logic              room,
	sbl_token_if.source       tokens
);
	import sbl_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	result_t         entry_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic [1:0]      push_n;
	logic            pop;
	result_t         head;

	// Room for a whole byte's worth of results
	assign room   = cnt_q <= CW'(DEPTH - 2);
	assign push_n = push ? din.count : 2'd0;
	assign pop    = tokens.valid && tokens.ready;
	assign head   = entry_q[rd_q];

	assign tokens.valid         = cnt_q != '0;
	assign tokens.token_offset  = head.token_offset;
	assign tokens.token_size    = head.token_size;
	assign tokens.token_line_no = head.token_line_no;
	assign tokens.end_marker    = head.end_marker;
	assign tokens.open_string   = head.open_string;

	// Store incoming results
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_q] <= din.first;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_q + AW'(1)] <= din.second;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push_n);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue overfilled");

	a_pair_counted: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 && !pop |=> cnt_q == $past(cnt_q) + CW'(2))
		else $error("pair of results not counted");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> CW'(push_n) + cnt_q <= CW'(DEPTH))
		else $error("push beyond queue depth");

endmodule

// ===== test/script_byte_lexer_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the script byte lexer: directed table, then predicted random scripts.
module script_byte_lexer_tb;
	import sbl_pkg::*;

	localparam int N_DIR    = 24;
	localparam int N_RANDOM = 1950;
	localparam int QUIET    = 300;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sbl_byte_if  chars_if ();
	sbl_token_if tokens_if ();

	script_byte_lexer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	always #1 clk = ~clk;

	// Predictor state
	lex_mode_t   lx_mode;
	logic [31:0] lx_pos;
	logic [31:0] lx_begin;
	logic [31:0] lx_line;
	result_t     step_res [2];
	int          step_cnt;

	result_t pending_tokens [$];
	bit      gaps_on;
	int      mismatches;
	int      bytes_sent;
	int      scripts_done;
	int      results_checked;
	int      open_ends;

	// Start, extremes, and each way the final byte can close a script
	dir_row_t dir_rows [N_DIR] = '{
		'{8'h61,        1'b1, 1'b1, '{32'd0, 32'd1, 32'd1, 1'b1, 1'b0}},
		'{CH_SPACE,     1'b1, 1'b1, '{32'd1, 32'd0, 32'd1, 1'b1, 1'b0}},
		'{CH_LF,        1'b1, 1'b1, '{32'd1, 32'd0, 32'd2, 1'b1, 1'b0}},
		'{CH_QUOTE,     1'b1, 1'b1, '{32'd0, 32'd1, 32'd1, 1'b1, 1'b1}},
		'{CH_COMMA,     1'b1, 1'b1, '{32'd0, 32'd1, 32'd1, 1'b1, 1'b0}},
		'{8'hFF,        1'b1, 1'b1, '{32'd0, 32'd1, 32'd1, 1'b1, 1'b0}},
		'{CH_HASH,      1'b1, 1'b1, '{32'd1, 32'd0, 32'd1, 1'b1, 1'b0}},
		'{CH_NUL,       1'b0, 1'b0, '0},
		'{8'h80,        1'b0, 1'b0, '0},
		'{CH_LPAREN,    1'b0, 1'b0, '0},
		'{CH_QUOTE,     1'b0, 1'b0, '0},
		'{CH_BACKSLASH, 1'b0, 1'b0, '0},
		'{CH_LF,        1'b0, 1'b0, '0},
		'{CH_LF,        1'b0, 1'b0, '0},
		'{CH_QUOTE,     1'b0, 1'b0, '0},
		'{CH_HASH,      1'b0, 1'b0, '0},
		'{CH_QUOTE,     1'b0, 1'b0, '0},
		'{CH_LF,        1'b0, 1'b0, '0},
		'{8'h7A,        1'b0, 1'b0, '0},
		'{CH_TAB,       1'b0, 1'b0, '0},
		'{8'h5F,        1'b0, 1'b0, '0},
		'{CH_PIPE,      1'b1, 1'b0, '0},
		'{CH_QUOTE,     1'b0, 1'b0, '0},
		'{CH_BACKSLASH, 1'b1, 1'b0, '0}
	};

	function automatic byte_class_t classify_byte(input logic [7:0] c);
		if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT, CH_NUL})
			return CLS_SPACE;
		if (c inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET,
				CH_RBRACKET, CH_COLON, CH_COMMA, CH_EQUALS, CH_PLUS, CH_MINUS,
				CH_STAR, CH_SLASH, CH_AMP, CH_PIPE})
			return CLS_DELIM;
		return CLS_ORDINARY;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic void clear_lexer();
		lx_mode  = LEX_IDLE;
		lx_pos   = '0;
		lx_begin = '0;
		lx_line  = 32'd1;
	endfunction

	function automatic void add_token(input logic [31:0] off, input logic [31:0] size,
			input logic endm, input logic open);
		step_res[step_cnt] = '{off, size, lx_line, endm, open};
		step_cnt++;
	endfunction

	// Work out the token results that one byte causes and advance the state
	function automatic void predict_tokens(input logic [7:0] c, input logic fin);
		logic [31:0] p;
		logic [31:0] np;
		byte_class_t cls;
		p = lx_pos;
		np = sat_inc(lx_pos);
		cls = classify_byte(c);
		step_cnt = 0;
		if (c == CH_LF)
			lx_line = sat_inc(lx_line);
		case (lx_mode)
			LEX_STRING: begin
				if (c == CH_BACKSLASH)
					lx_mode = LEX_ESCAPE;
				else if (c == CH_QUOTE)
					lx_mode = LEX_TOKEN;
			end
			LEX_ESCAPE: lx_mode = LEX_STRING;
			LEX_COMMENT: begin
				if (c == CH_LF)
					lx_mode = LEX_IDLE;
			end
			LEX_TOKEN: begin
				if (c == CH_HASH) begin
					add_token(lx_begin, p - lx_begin, 1'b0, 1'b0);
					lx_mode = LEX_COMMENT;
				end else if (c == CH_QUOTE) begin
					lx_mode = LEX_STRING;
				end else if (cls == CLS_SPACE) begin
					add_token(lx_begin, p - lx_begin, 1'b0, 1'b0);
					lx_mode = LEX_IDLE;
				end else if (cls == CLS_DELIM) begin
					add_token(lx_begin, p - lx_begin, 1'b0, 1'b0);
					add_token(p, 32'd1, 1'b0, 1'b0);
					lx_mode = LEX_IDLE;
				end
			end
			default: begin
				if (c == CH_HASH) begin
					lx_mode = LEX_COMMENT;
				end else if (c == CH_QUOTE || cls == CLS_ORDINARY) begin
					lx_begin = p;
					lx_mode = (c == CH_QUOTE) ? LEX_STRING : LEX_TOKEN;
				end else begin
					if (cls == CLS_DELIM)
						add_token(p, 32'd1, 1'b0, 1'b0);
					lx_mode = LEX_IDLE;
				end
			end
		endcase
		lx_pos = np;
		// Close the script: flush a pending token, mark the last result or add an empty one
		if (fin) begin
			if (lx_mode inside {LEX_TOKEN, LEX_STRING, LEX_ESCAPE})
				add_token(lx_begin, np - lx_begin, 1'b1, lx_mode != LEX_TOKEN);
			else if (step_cnt > 0)
				step_res[step_cnt - 1].end_marker = 1'b1;
			else
				add_token(np, 32'd0, 1'b1, 1'b0);
			clear_lexer();
		end
	endfunction

	// Offer one byte request, wait for it to be taken, then queue its tokens
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input result_t want);
		while (gaps_on && $urandom_range(99) < 31) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid      <= 1'b1;
		chars_if.data_byte  <= b;
		chars_if.final_byte <= fin;
		do @(posedge clk); while (!chars_if.ready);
		predict_tokens(b, fin);
		if (typed)
			pending_tokens = {pending_tokens, want};
		else
			for (int i = 0; i < step_cnt; i++)
				pending_tokens = {pending_tokens, step_res[i]};
		bytes_sent++;
		if (fin)
			scripts_done++;
	endtask

	// Hold the input until every expected token has come out
	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Build one script, well formed or noise, and send it with the final byte marked
	task automatic send_script(input bit noise);
		logic [7:0] text [$];
		logic [7:0] b;
		int pieces;
		pieces = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 15);
		if (noise) begin
			repeat ($urandom_range(1, 40))
				text = {text, 8'($urandom_range(255))};
		end else begin
			repeat (pieces) begin
				case ($urandom_range(99)) inside
					[0:34]: begin
						repeat ($urandom_range(1, 8)) begin
							do b = 8'($urandom_range(255));
							while (classify_byte(b) != CLS_ORDINARY || b == CH_QUOTE
								|| b == CH_HASH);
							text = {text, b};
						end
					end
					[35:54]: begin
						case ($urandom_range(6))
							0: text = {text, CH_SPACE};
							1: text = {text, CH_TAB};
							2: text = {text, CH_LF};
							3: text = {text, CH_CR};
							4: text = {text, CH_FF};
							5: text = {text, CH_VT};
							default: text = {text, CH_NUL};
						endcase
					end
					[55:74]: begin
						case ($urandom_range(14))
							0: text = {text, CH_LPAREN};
							1: text = {text, CH_RPAREN};
							2: text = {text, CH_LBRACE};
							3: text = {text, CH_RBRACE};
							4: text = {text, CH_LBRACKET};
							5: text = {text, CH_RBRACKET};
							6: text = {text, CH_COLON};
							7: text = {text, CH_COMMA};
							8: text = {text, CH_EQUALS};
							9: text = {text, CH_PLUS};
							10: text = {text, CH_MINUS};
							11: text = {text, CH_STAR};
							12: text = {text, CH_SLASH};
							13: text = {text, CH_AMP};
							default: text = {text, CH_PIPE};
						endcase
					end
					[75:86]: begin
						// String with escapes; now and then left open
						text = {text, CH_QUOTE};
						repeat ($urandom_range(0, 8)) begin
							if ($urandom_range(3) == 0) begin
								text = {text, CH_BACKSLASH};
								text = {text, 8'($urandom_range(255))};
							end else begin
								do b = 8'($urandom_range(255));
								while (b == CH_QUOTE || b == CH_BACKSLASH);
								text = {text, b};
							end
						end
						if ($urandom_range(9) != 0)
							text = {text, CH_QUOTE};
					end
					[87:94]: begin
						text = {text, CH_HASH};
						repeat ($urandom_range(0, 10)) begin
							do b = 8'($urandom_range(255));
							while (b == CH_LF);
							text = {text, b};
						end
						if ($urandom_range(7) != 0)
							text = {text, CH_LF};
					end
					default: text = {text, 8'($urandom_range(255))};
				endcase
			end
		end
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1, 1'b0, '0);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each token taken from the output with the oldest expectation
	always @(posedge clk) begin : token_check
		result_t want;
		if (arst_n === 1'b1 && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1) begin
			if (pending_tokens.size() == 0) begin
				$error("token with none expected: offset %0d size %0d line %0d",
					tokens_if.token_offset, tokens_if.token_size, tokens_if.token_line_no);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_offset", want.token_offset, tokens_if.token_offset);
				check_field("token_size", want.token_size, tokens_if.token_size);
				check_field("token_line_no", want.token_line_no, tokens_if.token_line_no);
				check_field("end_marker", 32'(want.end_marker), 32'(tokens_if.end_marker));
				check_field("open_string", 32'(want.open_string),
					32'(tokens_if.open_string));
			end
			results_checked++;
			if (tokens_if.open_string === 1'b1)
				open_ends++;
		end
	end

	// Drive the output ready, stalling at random while gaps are on
	initial begin
		tokens_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tokens_if.ready <= gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
		end
	end

	// Give up on a hung run
	initial begin
		#2_000_000;
		$display("script_byte_lexer_tb NOT OK");
		$finish;
	end

	initial begin
		clear_lexer();
		gaps_on = 1'b1;
		mismatches = 0;
		bytes_sent = 0;
		scripts_done = 0;
		results_checked = 0;
		open_ends = 0;
		arst_n              <= 1'b0;
		chars_if.valid      <= 1'b0;
		chars_if.data_byte  <= '0;
		chars_if.final_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, then pause until it has all come out
		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		// Random scripts: a quiet stretch first, then gaps on both sides
		gaps_on = 1'b0;
		while (bytes_sent < N_DIR + N_RANDOM) begin
			send_script($urandom_range(4) == 0);
			if (bytes_sent > N_DIR + QUIET)
				gaps_on = 1'b1;
			if ($urandom_range(9) == 0)
				wait_drained();
		end
		gaps_on = 1'b0;
		wait_drained();

		$display("Lexed %0d bytes in %0d scripts, %0d of them from the directed table.",
			bytes_sent, scripts_done, N_DIR);
		$display("Checked %0d token results, %0d of them closing on an open string.",
			results_checked, open_ends);
		if (mismatches == 0)
			$display("script_byte_lexer_tb OK");
		else
			$display("script_byte_lexer_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sbl_pkg.sv
hdl/sbl_if.sv
hdl/sbl_core.sv
hdl/sbl_queue.sv
hdl/script_byte_lexer.sv
test/script_byte_lexer_tb.sv
